// ----- rtl/plx_pkg.sv -----
// ============================================================================
// plx_pkg - shared types, constants and helpers for the pseudocode lexer
// Token kinds, character codes, keyword table and saturating counter helpers.
// ============================================================================
package plx_pkg;

    // Field widths
    localparam int CNT_W  = 16;
    localparam int OFF_W  = 24;
    localparam int KIND_W = 6;
    localparam int NKW    = 13;

    // Output queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [OFF_W-1:0] OFF_MAX = {OFF_W{1'b1}};

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_EOF     = 6'd0;
    localparam logic [KIND_W-1:0] KIND_EOL     = 6'd1;
    localparam logic [KIND_W-1:0] KIND_IDENT   = 6'd2;
    localparam logic [KIND_W-1:0] KIND_INT     = 6'd3;
    localparam logic [KIND_W-1:0] KIND_REAL    = 6'd4;
    localparam logic [KIND_W-1:0] KIND_STRING  = 6'd5;
    localparam logic [KIND_W-1:0] KIND_PLUS    = 6'd6;
    localparam logic [KIND_W-1:0] KIND_MINUS   = 6'd7;
    localparam logic [KIND_W-1:0] KIND_ARROW   = 6'd8;
    localparam logic [KIND_W-1:0] KIND_STAR    = 6'd9;
    localparam logic [KIND_W-1:0] KIND_SLASH   = 6'd10;
    localparam logic [KIND_W-1:0] KIND_EQ      = 6'd11;
    localparam logic [KIND_W-1:0] KIND_LT      = 6'd12;
    localparam logic [KIND_W-1:0] KIND_LE      = 6'd13;
    localparam logic [KIND_W-1:0] KIND_GT      = 6'd14;
    localparam logic [KIND_W-1:0] KIND_GE      = 6'd15;
    localparam logic [KIND_W-1:0] KIND_LPAREN  = 6'd16;
    localparam logic [KIND_W-1:0] KIND_RPAREN  = 6'd17;
    localparam logic [KIND_W-1:0] KIND_COMMA   = 6'd18;
    localparam logic [KIND_W-1:0] KIND_COLON   = 6'd19;
    localparam logic [KIND_W-1:0] KIND_LBRACK  = 6'd20;
    localparam logic [KIND_W-1:0] KIND_RBRACK  = 6'd21;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 6'd22;
    localparam logic [KIND_W-1:0] KIND_KW0     = 6'd23;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_D0     = 8'h30;
    localparam logic [7:0] CH_D9     = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;

    // Keyword table, right-aligned text
    localparam logic [71:0] KW_TEXT [NKW] = '{
        "algoritmo", "escribir", "falso", "fin", "func", "hacer", "hasta",
        "inicio", "para", "proc", "var", "verdadero", "or"
    };
    localparam logic [3:0] KW_LEN [NKW] = '{
        4'd9, 4'd8, 4'd5, 4'd3, 4'd4, 4'd5, 4'd5, 4'd6, 4'd4, 4'd4, 4'd3, 4'd9, 4'd2
    };

    // Scanner modes
    typedef enum logic [7:0] {
        MODE_IDLE    = 8'b0000_0001,
        MODE_IDENT   = 8'b0000_0010,
        MODE_INT     = 8'b0000_0100,
        MODE_REAL    = 8'b0000_1000,
        MODE_STRING  = 8'b0001_0000,
        MODE_MINUS   = 8'b0010_0000,
        MODE_LESS    = 8'b0100_0000,
        MODE_GREATER = 8'b1000_0000
    } mode_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CNT_W-1:0]  line;
        logic [CNT_W-1:0]  col;
        logic [OFF_W-1:0]  offset;
        logic [CNT_W-1:0]  len;
        logic              last;
    } tok_t;

    // Tokens produced by one accepted byte
    typedef struct packed {
        logic [1:0] cnt;
        tok_t       tok0;
        tok_t       tok1;
    } step_out_t;

    function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] v);
        sat_cnt = (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [OFF_W-1:0] sat_off(input logic [OFF_W-1:0] v);
        sat_off = (v == OFF_MAX) ? v : v + 1'b1;
    endfunction

    // Character of keyword k at position pos (zero past its end)
    function automatic logic [7:0] kw_char(input int k, input logic [3:0] pos);
        int base;
        base = 8 * (int'(KW_LEN[k]) - 1 - int'(pos));
        kw_char = (pos < KW_LEN[k]) ? KW_TEXT[k][base +: 8] : 8'h00;
    endfunction

    // Drop keywords that no longer match the identifier prefix
    function automatic logic [NKW-1:0] filter_hits(input logic [NKW-1:0] hits,
                                                   input logic [CNT_W-1:0] len,
                                                   input logic [7:0] c);
        logic [NKW-1:0] res;
        for (int k = 0; k < NKW; k++) begin
            res[k] = hits[k] && (len < CNT_W'(KW_LEN[k])) && (kw_char(k, len[3:0]) == c);
        end
        filter_hits = res;
    endfunction

    // First keyword that matched fully, else identifier
    function automatic logic [KIND_W-1:0] ident_kind(input logic [NKW-1:0] hits,
                                                     input logic [CNT_W-1:0] len);
        logic [KIND_W-1:0] res;
        res = KIND_IDENT;
        for (int k = NKW - 1; k >= 0; k--) begin
            if (hits[k] && (len == CNT_W'(KW_LEN[k]))) begin
                res = KIND_KW0 + KIND_W'(k);
            end
        end
        ident_kind = res;
    endfunction

    function automatic tok_t make_tok(input logic [KIND_W-1:0] kind,
                                      input logic [CNT_W-1:0] line,
                                      input logic [CNT_W-1:0] col,
                                      input logic [OFF_W-1:0] offset,
                                      input logic [CNT_W-1:0] len);
        tok_t t;
        t.kind   = kind;
        t.line   = line;
        t.col    = col;
        t.offset = offset;
        t.len    = len;
        t.last   = 1'b0;
        make_tok = t;
    endfunction

endpackage

// ----- rtl/plx_scan.sv -----
// ============================================================================
// plx_scan - lexer state registers and single-pass byte step
// Holds the open token and position counters; each accepted byte yields
// zero, one or two tokens in the same cycle.
// ============================================================================
module plx_scan (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  logic [7:0]          char_byte,
    output plx_pkg::step_out_t  step
);

    plx_pkg::mode_t                  mode_reg, mode_next;
    logic                            eol_reg, eol_next;
    logic                            ended_reg, ended_next;
    logic [plx_pkg::CNT_W-1:0]       line_reg, line_next;
    logic [plx_pkg::CNT_W-1:0]       col_reg, col_next;
    logic [plx_pkg::OFF_W-1:0]       off_reg, off_next;
    logic [plx_pkg::CNT_W-1:0]       scol_reg, scol_next;
    logic [plx_pkg::OFF_W-1:0]       soff_reg, soff_next;
    logic [plx_pkg::CNT_W-1:0]       len_reg, len_next;
    logic [plx_pkg::NKW-1:0]         hits_reg, hits_next;

    // State update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= plx_pkg::MODE_IDLE;
            eol_reg   <= 1'b0;
            ended_reg <= 1'b0;
            line_reg  <= plx_pkg::CNT_W'(1);
            col_reg   <= plx_pkg::CNT_W'(1);
            off_reg   <= '0;
            scol_reg  <= plx_pkg::CNT_W'(1);
            soff_reg  <= '0;
            len_reg   <= '0;
            hits_reg  <= '0;
        end else begin
            mode_reg  <= mode_next;
            eol_reg   <= eol_next;
            ended_reg <= ended_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            off_reg   <= off_next;
            scol_reg  <= scol_next;
            soff_reg  <= soff_next;
            len_reg   <= len_next;
            hits_reg  <= hits_next;
        end
    end

    // Process one byte
    always_comb begin
        logic                           fresh;
        logic                           fr_emit;
        logic [plx_pkg::KIND_W-1:0]     fr_kind;
        logic                           single_op;
        logic                           open_tok;
        plx_pkg::mode_t                 open_mode;
        logic [7:0]                     second;
        logic [plx_pkg::KIND_W-1:0]     single;
        logic                           is_alpha;
        logic                           is_digit;
        plx_pkg::tok_t                  t0;
        plx_pkg::tok_t                  t1;
        plx_pkg::tok_t                  fr_tok;
        logic [1:0]                     n;

        mode_next  = mode_reg;
        eol_next   = eol_reg;
        ended_next = ended_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        off_next   = off_reg;
        scol_next  = scol_reg;
        soff_next  = soff_reg;
        len_next   = len_reg;
        hits_next  = hits_reg;

        fresh     = 1'b1;
        fr_emit   = 1'b0;
        fr_kind   = plx_pkg::KIND_ERROR;
        single_op = 1'b0;
        open_tok  = 1'b0;
        open_mode = plx_pkg::MODE_IDLE;
        second    = plx_pkg::CH_EQ;
        single    = plx_pkg::KIND_LT;
        t0        = '0;
        t1        = '0;
        fr_tok    = '0;
        n         = 2'd0;

        is_alpha = (char_byte inside {[plx_pkg::CH_LA:plx_pkg::CH_LZ],
                                      [plx_pkg::CH_UA:plx_pkg::CH_UZ]});
        is_digit = (char_byte inside {[plx_pkg::CH_D0:plx_pkg::CH_D9]});

        if (fire) begin
            if (ended_reg) begin
                // After end of text: repeat EOF in place
                t0 = plx_pkg::make_tok(plx_pkg::KIND_EOF, line_reg, col_reg, off_reg,
                                       plx_pkg::CNT_W'(1));
                n  = 2'd1;
            end else begin
                // Continue or close the open token
                case (mode_reg)
                    plx_pkg::MODE_IDENT: begin
                        if (is_alpha || is_digit) begin
                            hits_next = plx_pkg::filter_hits(hits_reg, len_reg, char_byte);
                            len_next  = plx_pkg::sat_cnt(len_reg);
                            col_next  = plx_pkg::sat_cnt(col_reg);
                            off_next  = plx_pkg::sat_off(off_reg);
                            fresh     = 1'b0;
                        end else begin
                            t0 = plx_pkg::make_tok(plx_pkg::ident_kind(hits_reg, len_reg),
                                                   line_reg, scol_reg, soff_reg, len_reg);
                            n  = 2'd1;
                        end
                    end
                    plx_pkg::MODE_INT: begin
                        if (is_digit || char_byte == plx_pkg::CH_DOT) begin
                            if (char_byte == plx_pkg::CH_DOT) begin
                                mode_next = plx_pkg::MODE_REAL;
                            end
                            len_next = plx_pkg::sat_cnt(len_reg);
                            col_next = plx_pkg::sat_cnt(col_reg);
                            off_next = plx_pkg::sat_off(off_reg);
                            fresh    = 1'b0;
                        end else begin
                            t0 = plx_pkg::make_tok(plx_pkg::KIND_INT, line_reg, scol_reg,
                                                   soff_reg, len_reg);
                            n  = 2'd1;
                        end
                    end
                    plx_pkg::MODE_REAL: begin
                        if (is_digit) begin
                            len_next = plx_pkg::sat_cnt(len_reg);
                            col_next = plx_pkg::sat_cnt(col_reg);
                            off_next = plx_pkg::sat_off(off_reg);
                            fresh    = 1'b0;
                        end else begin
                            t0 = plx_pkg::make_tok(plx_pkg::KIND_REAL, line_reg, scol_reg,
                                                   soff_reg, len_reg);
                            n  = 2'd1;
                        end
                    end
                    plx_pkg::MODE_STRING: begin
                        if (char_byte == plx_pkg::CH_QUOTE) begin
                            t0 = plx_pkg::make_tok(plx_pkg::KIND_STRING, line_reg, scol_reg,
                                                   soff_reg, len_reg);
                            n        = 2'd1;
                            col_next = plx_pkg::sat_cnt(col_reg);
                            off_next = plx_pkg::sat_off(off_reg);
                            fresh    = 1'b0;
                        end else if (char_byte == plx_pkg::CH_NUL) begin
                            // Cut-off string: emit it, EOF follows
                            t0 = plx_pkg::make_tok(plx_pkg::KIND_STRING, line_reg, scol_reg,
                                                   soff_reg, len_reg);
                            n  = 2'd1;
                        end else begin
                            len_next = plx_pkg::sat_cnt(len_reg);
                            col_next = plx_pkg::sat_cnt(col_reg);
                            off_next = plx_pkg::sat_off(off_reg);
                            fresh    = 1'b0;
                        end
                    end
                    plx_pkg::MODE_MINUS, plx_pkg::MODE_LESS, plx_pkg::MODE_GREATER: begin
                        if (mode_reg == plx_pkg::MODE_MINUS) begin
                            second = plx_pkg::CH_GT;
                            single = plx_pkg::KIND_MINUS;
                        end else if (mode_reg == plx_pkg::MODE_LESS) begin
                            second = plx_pkg::CH_EQ;
                            single = plx_pkg::KIND_LT;
                        end else begin
                            second = plx_pkg::CH_EQ;
                            single = plx_pkg::KIND_GT;
                        end
                        if (char_byte == second) begin
                            t0 = plx_pkg::make_tok(single + 1'b1, line_reg, scol_reg,
                                                   soff_reg, plx_pkg::CNT_W'(2));
                            n        = 2'd1;
                            col_next = plx_pkg::sat_cnt(col_reg);
                            off_next = plx_pkg::sat_off(off_reg);
                            fresh    = 1'b0;
                        end else begin
                            t0 = plx_pkg::make_tok(single, line_reg, scol_reg, soff_reg,
                                                   plx_pkg::CNT_W'(1));
                            n  = 2'd1;
                        end
                    end
                    default: ;
                endcase

                // Any token from a held mode arms EOL
                if (n != 2'd0) begin
                    eol_next = 1'b1;
                end

                if (fresh) begin
                    // Handle the byte as a new one
                    mode_next = plx_pkg::MODE_IDLE;
                    case (char_byte)
                        plx_pkg::CH_SPACE, plx_pkg::CH_TAB, plx_pkg::CH_CR: begin
                            col_next = plx_pkg::sat_cnt(col_reg);
                            off_next = plx_pkg::sat_off(off_reg);
                        end
                        plx_pkg::CH_LF: begin
                            if (eol_next) begin
                                fr_emit  = 1'b1;
                                fr_kind  = plx_pkg::KIND_EOL;
                                eol_next = 1'b0;
                            end
                            line_next = plx_pkg::sat_cnt(line_reg);
                            col_next  = plx_pkg::CNT_W'(1);
                            off_next  = plx_pkg::sat_off(off_reg);
                        end
                        plx_pkg::CH_QUOTE: begin
                            mode_next = plx_pkg::MODE_STRING;
                            scol_next = col_reg;
                            col_next  = plx_pkg::sat_cnt(col_reg);
                            off_next  = plx_pkg::sat_off(off_reg);
                            soff_next = plx_pkg::sat_off(off_reg);
                            len_next  = '0;
                        end
                        plx_pkg::CH_MINUS: begin
                            open_tok  = 1'b1;
                            open_mode = plx_pkg::MODE_MINUS;
                        end
                        plx_pkg::CH_LT: begin
                            open_tok  = 1'b1;
                            open_mode = plx_pkg::MODE_LESS;
                        end
                        plx_pkg::CH_GT: begin
                            open_tok  = 1'b1;
                            open_mode = plx_pkg::MODE_GREATER;
                        end
                        plx_pkg::CH_PLUS: begin
                            single_op = 1'b1;
                            fr_kind   = plx_pkg::KIND_PLUS;
                        end
                        plx_pkg::CH_STAR: begin
                            single_op = 1'b1;
                            fr_kind   = plx_pkg::KIND_STAR;
                        end
                        plx_pkg::CH_SLASH: begin
                            single_op = 1'b1;
                            fr_kind   = plx_pkg::KIND_SLASH;
                        end
                        plx_pkg::CH_EQ: begin
                            single_op = 1'b1;
                            fr_kind   = plx_pkg::KIND_EQ;
                        end
                        plx_pkg::CH_LPAREN: begin
                            single_op = 1'b1;
                            fr_kind   = plx_pkg::KIND_LPAREN;
                        end
                        plx_pkg::CH_RPAREN: begin
                            single_op = 1'b1;
                            fr_kind   = plx_pkg::KIND_RPAREN;
                        end
                        plx_pkg::CH_COMMA: begin
                            single_op = 1'b1;
                            fr_kind   = plx_pkg::KIND_COMMA;
                        end
                        plx_pkg::CH_COLON: begin
                            single_op = 1'b1;
                            fr_kind   = plx_pkg::KIND_COLON;
                        end
                        plx_pkg::CH_LBRACK: begin
                            single_op = 1'b1;
                            fr_kind   = plx_pkg::KIND_LBRACK;
                        end
                        plx_pkg::CH_RBRACK: begin
                            single_op = 1'b1;
                            fr_kind   = plx_pkg::KIND_RBRACK;
                        end
                        plx_pkg::CH_NUL: begin
                            fr_emit    = 1'b1;
                            fr_kind    = plx_pkg::KIND_EOF;
                            ended_next = 1'b1;
                        end
                        default: begin
                            if (is_alpha) begin
                                hits_next = plx_pkg::filter_hits({plx_pkg::NKW{1'b1}}, '0,
                                                                 char_byte);
                                open_tok  = 1'b1;
                                open_mode = plx_pkg::MODE_IDENT;
                            end else if (is_digit) begin
                                open_tok  = 1'b1;
                                open_mode = plx_pkg::MODE_INT;
                            end else begin
                                single_op = 1'b1;
                                fr_kind   = plx_pkg::KIND_ERROR;
                            end
                        end
                    endcase

                    // Open a held token at the current position
                    if (open_tok) begin
                        mode_next = open_mode;
                        scol_next = col_reg;
                        soff_next = off_reg;
                        len_next  = plx_pkg::CNT_W'(1);
                        col_next  = plx_pkg::sat_cnt(col_reg);
                        off_next  = plx_pkg::sat_off(off_reg);
                    end

                    // Emit a one-byte token and advance
                    if (single_op) begin
                        fr_emit  = 1'b1;
                        col_next = plx_pkg::sat_cnt(col_reg);
                        off_next = plx_pkg::sat_off(off_reg);
                    end

                    if (fr_emit) begin
                        fr_tok = plx_pkg::make_tok(fr_kind, line_reg, col_reg, off_reg,
                                                   plx_pkg::CNT_W'(1));
                        if (fr_kind != plx_pkg::KIND_EOF && fr_kind != plx_pkg::KIND_EOL) begin
                            eol_next = 1'b1;
                        end
                        if (n == 2'd0) begin
                            t0 = fr_tok;
                        end else begin
                            t1 = fr_tok;
                        end
                        n = n + 2'd1;
                    end
                end else if (n != 2'd0) begin
                    mode_next = plx_pkg::MODE_IDLE;
                end
            end
        end

        // Mark the final token of this byte
        if (n == 2'd1) begin
            t0.last = 1'b1;
        end
        if (n == 2'd2) begin
            t1.last = 1'b1;
        end

        step.cnt  = n;
        step.tok0 = t0;
        step.tok1 = t1;
    end

endmodule

// ----- rtl/plx_tok_fifo.sv -----
// ============================================================================
// plx_tok_fifo - token result queue
// Takes up to two tokens per cycle from the scanner and hands out one token
// per output transfer.
// ============================================================================
module plx_tok_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  plx_pkg::step_out_t  step,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output plx_pkg::tok_t       out_tok
);

    plx_pkg::tok_t                 mem_reg [plx_pkg::QDEPTH];
    logic [plx_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [plx_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [plx_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                          pop;
    logic [plx_pkg::QPTR_W-1:0]    wr_ptr_inc;

    assign pop        = out_valid && out_ready;
    assign wr_ptr_inc = wr_ptr_reg + 1'b1;

    // Pointer and fill updates
    always_comb begin
        wr_ptr_next = wr_ptr_reg + plx_pkg::QPTR_W'(step.cnt);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + plx_pkg::QCNT_W'(step.cnt) - plx_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store incoming tokens
    always_ff @(posedge aclk) begin
        if (step.cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= step.tok0;
        end
        if (step.cnt == 2'd2) begin
            mem_reg[wr_ptr_inc] <= step.tok1;
        end
    end

    // Accept a byte only with room for two tokens
    assign room      = (count_reg <= plx_pkg::QCNT_W'(plx_pkg::QDEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_tok   = mem_reg[rd_ptr_reg];

endmodule

// ----- rtl/pseudocode_lexer.sv -----
// ============================================================================
// pseudocode_lexer - streaming tokenizer for a small pseudocode language
// Takes one source byte per transfer and produces tokens with position info.
// ============================================================================
//
//  Channel  Direction  Handshake            Payload
//  s_       in         s_valid / s_ready    s_char_byte
//  m_       out        m_valid / m_ready    m_tok_kind, m_tok_line, m_tok_col,
//                                           m_tok_offset, m_tok_len, m_last_of_run
//
//  One byte is accepted per cycle while s_ready is high; its tokens (zero, one
//  or two) are written into a four-entry token queue at the end of that cycle,
//  and the first of them is visible on m_ the next cycle if the queue was empty.
//  s_ready is high while the queue has room for two tokens, so bytes that yield
//  two tokens back to back, or a stalled m_ side, throttle input.
//  aresetn is synchronous and active low and clears lexer state and queue.
//
module pseudocode_lexer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_char_byte,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [plx_pkg::KIND_W-1:0]   m_tok_kind,
    output logic [plx_pkg::CNT_W-1:0]    m_tok_line,
    output logic [plx_pkg::CNT_W-1:0]    m_tok_col,
    output logic [plx_pkg::OFF_W-1:0]    m_tok_offset,
    output logic [plx_pkg::CNT_W-1:0]    m_tok_len,
    output logic                         m_last_of_run
);

    plx_pkg::step_out_t  step;
    plx_pkg::tok_t       tok;
    logic                fire;

    assign fire = s_valid && s_ready;

    // Lexer state and byte step
    plx_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .char_byte (s_char_byte),
        .step      (step)
    );

    // Token queue toward the m_ side
    plx_tok_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .room      (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_tok   (tok)
    );

    assign m_tok_kind    = tok.kind;
    assign m_tok_line    = tok.line;
    assign m_tok_col     = tok.col;
    assign m_tok_offset  = tok.offset;
    assign m_tok_len     = tok.len;
    assign m_last_of_run = tok.last;

endmodule
